FILE: rtl/core/polygon_clip_rect_pipeline_defines.svh
// Assertion macros used by the polygon clipper datapath.
`ifndef POLYGON_CLIP_RECT_PIPELINE_DEFINES_SVH
`define POLYGON_CLIP_RECT_PIPELINE_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define PCR_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define PCR_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/pcr_pkg.sv
// Package for the polygon clipper: types, codes and helper functions.
package pcr_pkg;

   localparam int COORD_BITS    = 16;
   localparam int NUM_STAGES    = 4;
   localparam int DIFF_BITS     = COORD_BITS + 1;
   localparam int PROD_BITS     = 2 * DIFF_BITS;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic        [DIFF_BITS-1:0]  mag_type;
   typedef logic signed [DIFF_BITS:0]    sum_type;
   typedef logic        [1:0]            stage_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

   typedef struct packed {
      coord_type x_min;
      coord_type x_max;
      coord_type y_min;
      coord_type y_max;
   } window_type;

   // Clip stages in cascade order
   localparam stage_type STAGE_LEFT   = 2'd0;
   localparam stage_type STAGE_RIGHT  = 2'd1;
   localparam stage_type STAGE_BOTTOM = 2'd2;
   localparam stage_type STAGE_TOP    = 2'd3;

   // Input word commands
   localparam logic CMD_VERTEX = 1'b0;
   localparam logic CMD_CLOSE  = 1'b1;

   // Register indexes
   localparam logic [1:0] REG_X_MIN = 2'd0;
   localparam logic [1:0] REG_X_MAX = 2'd1;
   localparam logic [1:0] REG_Y_MIN = 2'd2;
   localparam logic [1:0] REG_Y_MAX = 2'd3;

   // Datapath commands from the controller
   typedef enum logic [2:0] {
      DP_NOP,
      DP_LOAD,
      DP_FEED,
      DP_CLOSE,
      DP_POP,
      DP_FINISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      stage_type stage;
      logic      closing;
   } dp_cmd_type;

   typedef struct packed {
      logic cross_start;
      logic div_done;
      logic pend_any;
      logic pend_emit;
      logic out_blocked;
   } dp_status_type;

   localparam sum_type SAT_HI = sum_type'(2**(COORD_BITS-1) - 1);
   localparam sum_type SAT_LO = -SAT_HI - sum_type'(1);

   // Inside test of one clip boundary
   function automatic logic is_in(stage_type stage, point_type p, window_type w);
      logic r;
      case (stage)
         STAGE_LEFT:   r = $signed(p.x) >= $signed(w.x_min);
         STAGE_RIGHT:  r = $signed(p.x) <= $signed(w.x_max);
         STAGE_BOTTOM: r = $signed(p.y) <= $signed(w.y_max);
         default:      r = $signed(p.y) >= $signed(w.y_min);
      endcase
      return r;
   endfunction

   function automatic mag_type abs_mag(diff_type v);
      mag_type r;
      r = v[DIFF_BITS-1] ? mag_type'(-v) : mag_type'(v);
      return r;
   endfunction

   function automatic coord_type sat_coord(sum_type v);
      coord_type r;
      if (v > SAT_HI) r = coord_type'(SAT_HI);
      else if (v < SAT_LO) r = coord_type'(SAT_LO);
      else r = coord_type'(v);
      return r;
   endfunction

endpackage

FILE: rtl/core/pcr_if.sv
// Valid/ready channel interfaces for the clipper input and result words.
interface pcr_req_if import pcr_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      cmd;
   coord_type vertex_x;
   coord_type vertex_y;
   modport source (output valid, cmd, vertex_x, vertex_y, input ready);
   modport sink (input valid, cmd, vertex_x, vertex_y, output ready);
endinterface

interface pcr_rsp_if import pcr_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type out_x;
   coord_type out_y;
   logic      out_last;
   modport source (output valid, out_x, out_y, out_last, input ready);
   modport sink (input valid, out_x, out_y, out_last, output ready);
endinterface

FILE: rtl/core/polygon_clip_rect_pipeline.sv
// Rectangular-window polygon clipper top level: register port, controller and datapath.
//
// Vertex words of one polygon pass through left, right, bottom and top clip stages;
// a close word runs each stage's closing edge and clears the stages. One word is in
// work at a time: a vertex takes a feed, then a drain, per stage pass, between the
// accept and the finish, and each boundary crossing holds the controller in the
// shared multiply and bit-serial divide unit; the crossing point is then drained,
// and fed and drained through each later stage. A close word takes a close and a
// drain per stage plus its crossings. The last result of a word is marked out_last;
// one result is held back until the next one or the end of the word is known. Window
// registers sit at byte addresses 0, 4, 8 and 12 (x_min, x_max, y_min, y_max) and
// read back sign-extended.
module polygon_clip_rect_pipeline import pcr_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   pcr_req_if.sink                  req_if,
   pcr_rsp_if.source                rsp_if,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   window_type    win_ff;
   dp_cmd_type    dp_cmd;
   dp_status_type status;
   point_type     in_point;
   coord_type     wdata;
   logic [1:0]    reg_idx;

   assign reg_idx = csr_paddr[3:2];
   assign wdata   = csr_pwdata[COORD_BITS-1:0];

   // Write window registers
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff.x_min <= coord_type'(0);
         win_ff.x_max <= coord_type'(1023);
         win_ff.y_min <= coord_type'(0);
         win_ff.y_max <= coord_type'(767);
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (reg_idx)
            REG_X_MIN: win_ff.x_min <= wdata;
            REG_X_MAX: win_ff.x_max <= wdata;
            REG_Y_MIN: win_ff.y_min <= wdata;
            REG_Y_MAX: win_ff.y_max <= wdata;
            default: ;
         endcase
      end
   end

   // Read back sign-extended
   always_comb begin
      unique case (reg_idx)
         REG_X_MIN: csr_prdata = CSR_DATA_BITS'(win_ff.x_min);
         REG_X_MAX: csr_prdata = CSR_DATA_BITS'(win_ff.x_max);
         REG_Y_MIN: csr_prdata = CSR_DATA_BITS'(win_ff.y_min);
         REG_Y_MAX: csr_prdata = CSR_DATA_BITS'(win_ff.y_max);
         default:   csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign in_point.x = req_if.vertex_x;
   assign in_point.y = req_if.vertex_y;

   pcr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_cmd   (req_if.cmd),
      .req_ready (req_if.ready),
      .status    (status),
      .dp_cmd    (dp_cmd)
   );

   pcr_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .win      (win_ff),
      .cmd      (dp_cmd),
      .in_point (in_point),
      .status   (status),
      .rsp_if   (rsp_if)
   );

endmodule

FILE: rtl/core/pcr_divider.sv
// Crossing unit: one registered multiply, then restoring division one bit a cycle.
module pcr_divider import pcr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  mag_type a_mag,
   input  mag_type b_mag,
   input  mag_type d_mag,
   output logic    busy,
   output logic    done,
   output mag_type quotient
);

   localparam int CNT_BITS = $clog2(PROD_BITS + 1);

   logic                 busy_ff, done_ff;
   logic [CNT_BITS-1:0]  cnt_ff;
   logic [PROD_BITS-1:0] prod_ff, prod_in;
   mag_type              rem_ff, rem_in;
   mag_type              d_ff;
   logic [DIFF_BITS:0]   rem_sh;
   logic                 fits;

   // One restoring step
   always_comb begin
      rem_sh  = {rem_ff, prod_ff[PROD_BITS-1]};
      fits    = rem_sh >= {1'b0, d_ff};
      rem_in  = fits ? mag_type'(rem_sh - {1'b0, d_ff}) : mag_type'(rem_sh);
      prod_in = {prod_ff[PROD_BITS-2:0], fits};
   end

   // Sequence the iterations
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_BITS'(PROD_BITS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Product, then shift quotient bits into it
   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= PROD_BITS'(a_mag) * PROD_BITS'(b_mag);
         rem_ff  <= '0;
         d_ff    <= d_mag;
      end else if (busy_ff) begin
         prod_ff <= prod_in;
         rem_ff  <= rem_in;
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = prod_ff[DIFF_BITS-1:0];

endmodule

FILE: rtl/core/pcr_datapath.sv
// Clipper datapath: stage registers, pending words, crossing setup and output staging.
`include "polygon_clip_rect_pipeline_defines.svh"
module pcr_datapath import pcr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  window_type    win,
   input  dp_cmd_type    cmd,
   input  point_type     in_point,
   output dp_status_type status,
   pcr_rsp_if.source     rsp_if
);

   logic [NUM_STAGES-1:0] seen_ff, pc_v_ff, pv_v_ff;
   point_type             first_ff [NUM_STAGES];
   point_type             prev_ff  [NUM_STAGES];
   point_type             pc_ff    [NUM_STAGES];
   point_type             pv_ff    [NUM_STAGES];
   point_type             feed_ff, hold_ff, out_ff;
   stage_type             fstage_ff, xstage_ff;
   logic                  hold_v_ff, out_v_ff, out_last_ff;
   logic                  horiz_ff, neg_ff;
   coord_type             bound_ff, base_ff;

   stage_type sel_s, top;
   point_type old_prev, old_first, p1, p2, pop_pt, cross_pt;
   logic      feed_in, prev_in, first_in, cross_start, pend_any;
   logic      horiz, neg, emit_now;
   coord_type bound, a1, a2, o1, o2, res;
   diff_type  num, dy, den;
   sum_type   sum;
   logic      div_busy, div_done;
   mag_type   quot;

   // Evaluate the selected stage
   always_comb begin
      sel_s     = (cmd.op == DP_CLOSE) ? cmd.stage : fstage_ff;
      old_prev  = prev_ff[sel_s];
      old_first = first_ff[sel_s];
      feed_in   = is_in(sel_s, feed_ff, win);
      prev_in   = is_in(sel_s, old_prev, win);
      first_in  = is_in(sel_s, old_first, win);
      cross_start = ((cmd.op == DP_FEED) && seen_ff[sel_s] && (feed_in != prev_in)) ||
                    ((cmd.op == DP_CLOSE) && seen_ff[sel_s] && (prev_in != first_in));
      p1 = (cmd.op == DP_CLOSE) ? old_prev : feed_ff;
      p2 = (cmd.op == DP_CLOSE) ? old_first : old_prev;
   end

   // Set up the crossing against the stage boundary
   always_comb begin
      horiz = sel_s[1];
      if (horiz) bound = (sel_s == STAGE_BOTTOM) ? win.y_max : win.y_min;
      else       bound = (sel_s == STAGE_LEFT) ? win.x_min : win.x_max;
      a1  = horiz ? p1.y : p1.x;
      a2  = horiz ? p2.y : p2.x;
      o1  = horiz ? p1.x : p1.y;
      o2  = horiz ? p2.x : p2.y;
      num = diff_type'(bound) - diff_type'(a2);
      dy  = diff_type'(o1) - diff_type'(o2);
      den = diff_type'(a1) - diff_type'(a2);
      neg = num[DIFF_BITS-1] ^ dy[DIFF_BITS-1] ^ den[DIFF_BITS-1];
   end

   pcr_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cross_start),
      .a_mag    (abs_mag(num)),
      .b_mag    (abs_mag(dy)),
      .d_mag    (abs_mag(den)),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (quot)
   );

   // Finish the crossing point
   always_comb begin
      sum = neg_ff ? sum_type'(base_ff) - sum_type'({1'b0, quot})
                   : sum_type'(base_ff) + sum_type'({1'b0, quot});
      res = sat_coord(sum);
      cross_pt.x = horiz_ff ? res : bound_ff;
      cross_pt.y = horiz_ff ? bound_ff : res;
   end

   // Pick the deepest stage with pending work
   always_comb begin
      top = STAGE_LEFT;
      for (int i = 0; i < NUM_STAGES; i++) begin
         if (pc_v_ff[i] || pv_v_ff[i]) top = stage_type'(i);
      end
      pend_any = |(pc_v_ff | pv_v_ff);
      pop_pt   = pc_v_ff[top] ? pc_ff[top] : pv_ff[top];
   end

   // Move a held word into the result register
   assign emit_now = hold_v_ff && (((cmd.op == DP_POP) && (top == STAGE_TOP)) ||
                                   (cmd.op == DP_FINISH));

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff   <= '0;
         pc_v_ff   <= '0;
         pv_v_ff   <= '0;
         hold_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         if (emit_now) out_v_ff <= 1'b1;
         else if (rsp_if.valid && rsp_if.ready) out_v_ff <= 1'b0;
         case (cmd.op)
            DP_FEED: begin
               seen_ff[sel_s] <= 1'b1;
               pv_v_ff[sel_s] <= feed_in;
            end
            DP_POP: begin
               if (pc_v_ff[top]) pc_v_ff[top] <= 1'b0;
               else pv_v_ff[top] <= 1'b0;
               if (top == STAGE_TOP) hold_v_ff <= 1'b1;
            end
            DP_FINISH: begin
               if (hold_v_ff) hold_v_ff <= 1'b0;
               if (cmd.closing) seen_ff <= '0;
            end
            default: ;
         endcase
         if (div_done) pc_v_ff[xstage_ff] <= 1'b1;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      case (cmd.op)
         DP_LOAD: begin
            feed_ff   <= in_point;
            fstage_ff <= STAGE_LEFT;
         end
         DP_FEED: begin
            if (!seen_ff[sel_s]) first_ff[sel_s] <= feed_ff;
            prev_ff[sel_s] <= feed_ff;
            pv_ff[sel_s]   <= feed_ff;
         end
         DP_POP: begin
            if (top == STAGE_TOP) begin
               if (hold_v_ff) begin
                  out_ff      <= hold_ff;
                  out_last_ff <= 1'b0;
               end
               hold_ff <= pop_pt;
            end else begin
               feed_ff   <= pop_pt;
               fstage_ff <= top + stage_type'(1);
            end
         end
         DP_FINISH: begin
            if (hold_v_ff) begin
               out_ff      <= hold_ff;
               out_last_ff <= 1'b1;
            end
         end
         default: ;
      endcase
      if (cross_start) begin
         xstage_ff <= sel_s;
         horiz_ff  <= horiz;
         bound_ff  <= bound;
         base_ff   <= o2;
         neg_ff    <= neg;
      end
      if (div_done) pc_ff[xstage_ff] <= cross_pt;
   end

   assign status.cross_start = cross_start;
   assign status.div_done    = div_done;
   assign status.pend_any    = pend_any;
   assign status.pend_emit   = pend_any && (top == STAGE_TOP);
   assign status.out_blocked = hold_v_ff && out_v_ff;

   assign rsp_if.valid    = out_v_ff;
   assign rsp_if.out_x    = out_ff.x;
   assign rsp_if.out_y    = out_ff.y;
   assign rsp_if.out_last = out_last_ff;

   `PCR_ASSERT_IMP(a_emit_no_overwrite, (cmd.op == DP_POP) && (top == STAGE_TOP) && hold_v_ff, !out_v_ff, "emit would overwrite a waiting result")
   `PCR_ASSERT_IMP(a_div_free_at_start, cross_start, !div_busy, "crossing started while divider busy")
   `PCR_ASSERT_IMP(a_pop_has_work, cmd.op == DP_POP, pend_any, "pop with no pending vertex")
   `PCR_ASSERT_NEXT(a_done_leaves_work, div_done, pend_any, "crossing result not queued")

endmodule

FILE: rtl/core/pcr_ctrl.sv
// Clipper controller: sequences feed, crossing, drain, close and finish steps.
module pcr_ctrl import pcr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_cmd,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    dp_cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FEED,
      ST_DIV,
      ST_DRAIN,
      ST_CLOSE,
      ST_FINISH
   } state_type;

   state_type  state_ff, state_in;
   logic       closing_ff, closing_in;
   logic [2:0] cidx_ff, cidx_in;

   // Next state and datapath command
   always_comb begin
      state_in       = state_ff;
      closing_in     = closing_ff;
      cidx_in        = cidx_ff;
      dp_cmd.op      = DP_NOP;
      dp_cmd.stage   = cidx_ff[1:0];
      dp_cmd.closing = closing_ff;
      req_ready      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_cmd == CMD_VERTEX) begin
                  dp_cmd.op  = DP_LOAD;
                  closing_in = 1'b0;
                  state_in   = ST_FEED;
               end else begin
                  closing_in = 1'b1;
                  cidx_in    = '0;
                  state_in   = ST_CLOSE;
               end
            end
         end
         ST_FEED: begin
            dp_cmd.op = DP_FEED;
            state_in  = status.cross_start ? ST_DIV : ST_DRAIN;
         end
         ST_DIV: begin
            if (status.div_done) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (status.pend_any) begin
               if (!(status.pend_emit && status.out_blocked)) begin
                  dp_cmd.op = DP_POP;
                  if (!status.pend_emit) state_in = ST_FEED;
               end
            end else if (closing_ff && !cidx_ff[2]) begin
               state_in = ST_CLOSE;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_CLOSE: begin
            dp_cmd.op = DP_CLOSE;
            cidx_in   = cidx_ff + 3'd1;
            state_in  = status.cross_start ? ST_DIV : ST_DRAIN;
         end
         ST_FINISH: begin
            if (!status.out_blocked) begin
               dp_cmd.op = DP_FINISH;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         closing_ff <= 1'b0;
         cidx_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         closing_ff <= closing_in;
         cidx_ff    <= cidx_in;
      end
   end

endmodule

FILE: dv/polygon_clip_rect_pipeline_test.sv
// Self-checking testbench for the rectangular-window polygon clipper.
`timescale 1ns / 100ps

module polygon_clip_rect_pipeline_test;
   import pcr_pkg::*;

   typedef struct {
      longint x;
      longint y;
   } vtx_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      logic      last;
   } clip_word_type;

   typedef struct {
      logic      cmd;
      coord_type x;
      coord_type y;
      int        n_typed;   // -1: use the clip model, 0/1: typed result count
      coord_type ex;
      coord_type ey;
   } stim_row_type;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   pcr_req_if req_if ();
   pcr_rsp_if rsp_if ();

   polygon_clip_rect_pipeline dut (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Clip model state
   longint win_xl, win_xh, win_yl, win_yh;
   bit     seen_st[NUM_STAGES];
   vtx_type first_st[NUM_STAGES];
   vtx_type prev_st[NUM_STAGES];
   vtx_type clip_pts[$];
   clip_word_type pending_words[$];

   int  fail_count = 0;
   int  send_gap_pct = 10;
   int  recv_stall_pct = 63;
   bit  hold_rsp = 0;
   bit  accepted;

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   function automatic bit in_bound(int e, vtx_type p);
      case (e)
         STAGE_LEFT:   return p.x >= win_xl;
         STAGE_RIGHT:  return p.x <= win_xh;
         STAGE_BOTTOM: return p.y <= win_yh;
         default:      return p.y >= win_yl;
      endcase
   endfunction

   // Intersection of edge p1 (newer) to p2 (older) with boundary e
   function automatic vtx_type edge_cross(int e, vtx_type p1, vtx_type p2);
      vtx_type c;
      longint b;
      if (e < STAGE_BOTTOM) begin
         b = (e == STAGE_LEFT) ? win_xl : win_xh;
         c.x = b;
         c.y = p2.y + ((b - p2.x) * (p1.y - p2.y)) / (p1.x - p2.x);
      end else begin
         b = (e == STAGE_BOTTOM) ? win_yh : win_yl;
         c.y = b;
         c.x = p2.x + ((b - p2.y) * (p1.x - p2.x)) / (p1.y - p2.y);
      end
      return c;
   endfunction

   function automatic coord_type sat16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return coord_type'(v);
   endfunction

   // Push a list of points through one stage, return what leaves it
   function automatic void run_stage(int e, ref vtx_type pts[$]);
      vtx_type outq[$];
      foreach (pts[i]) begin
         if (!seen_st[e]) begin
            seen_st[e] = 1;
            first_st[e] = pts[i];
         end else if (in_bound(e, pts[i]) != in_bound(e, prev_st[e]))
            outq.push_back(edge_cross(e, pts[i], prev_st[e]));
         prev_st[e] = pts[i];
         if (in_bound(e, pts[i])) outq.push_back(pts[i]);
      end
      pts = outq;
   endfunction

   // Compute the clipped words caused by one input word into clip_pts
   function automatic void clip_word(logic cmd, coord_type x, coord_type y);
      vtx_type p;
      clip_pts.delete();
      if (cmd == CMD_VERTEX) begin
         p.x = x; p.y = y;
         clip_pts.push_back(p);
         for (int e = 0; e < NUM_STAGES; e++) run_stage(e, clip_pts);
      end else begin
         for (int e = 0; e < NUM_STAGES; e++) begin
            run_stage(e, clip_pts);
            if (seen_st[e] && in_bound(e, prev_st[e]) != in_bound(e, first_st[e]))
               clip_pts.push_back(edge_cross(e, prev_st[e], first_st[e]));
         end
         for (int e = 0; e < NUM_STAGES; e++) seen_st[e] = 0;
      end
   endfunction

   function automatic void queue_predicted();
      clip_word_type w;
      foreach (clip_pts[i]) begin
         w.x = sat16(clip_pts[i].x);
         w.y = sat16(clip_pts[i].y);
         w.last = (i == clip_pts.size() - 1);
         pending_words.push_back(w);
      end
   endfunction

   task automatic csr_write(logic [1:0] idx, coord_type v);
      @(posedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_BITS'({idx, 2'b00});
      csr_pwdata <= CSR_DATA_BITS'(signed'(v));
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (idx)
         REG_X_MIN: win_xl = v;
         REG_X_MAX: win_xh = v;
         REG_Y_MIN: win_yl = v;
         default:   win_yh = v;
      endcase
   endtask

   // Drain, let the block settle, then load a new window
   task automatic set_window(coord_type xl, coord_type xh, coord_type yl, coord_type yh);
      wait (pending_words.size() == 0);
      repeat (400) @(posedge clock);
      csr_write(REG_X_MIN, xl);
      csr_write(REG_X_MAX, xh);
      csr_write(REG_Y_MIN, yl);
      csr_write(REG_Y_MAX, yh);
   endtask

   // Offer one word and hold it until accepted
   task automatic send_word(logic cmd, coord_type x, coord_type y, int n_typed,
                            coord_type ex, coord_type ey);
      clip_word_type w;
      while ($urandom_range(99) < send_gap_pct) begin
         @(posedge clock);
         req_if.valid <= 1'b0;
      end
      @(posedge clock);
      req_if.valid <= 1'b1;
      req_if.cmd <= cmd;
      req_if.vertex_x <= x;
      req_if.vertex_y <= y;
      do @(posedge clock); while (!req_if.ready);
      req_if.valid <= 1'b0;
      clip_word(cmd, x, y);
      if (n_typed < 0) queue_predicted();
      else if (n_typed == 1) begin
         w.x = ex; w.y = ey; w.last = 1'b1;
         pending_words.push_back(w);
      end
   endtask

   function automatic coord_type rand_coord(int span);
      if ($urandom_range(9) == 0) return coord_type'($urandom);
      return coord_type'(int'($urandom_range(2 * span)) - span / 2);
   endfunction

   // Random polygons, with some noise words mixed in
   task automatic random_polys(int n_words, int span);
      int sent = 0;
      int nv;
      while (sent < n_words) begin
         if ($urandom_range(9) == 0) begin
            send_word(CMD_CLOSE, coord_type'($urandom), coord_type'($urandom), -1, 0, 0);
            sent++;
         end else begin
            nv = $urandom_range(8, 1);
            for (int i = 0; i < nv; i++)
               send_word(CMD_VERTEX, rand_coord(span), rand_coord(span), -1, 0, 0);
            send_word(CMD_CLOSE, coord_type'($urandom), coord_type'($urandom), -1, 0, 0);
            sent += nv + 1;
         end
      end
   endtask

   stim_row_type directed[$] = '{
      '{CMD_CLOSE,  16'sd0,      16'sd0,      0, 16'sd0,    16'sd0},
      '{CMD_VERTEX, 16'sd0,      16'sd0,      1, 16'sd0,    16'sd0},
      '{CMD_VERTEX, 16'sd2000,   16'sd100,    1, 16'sd1023, 16'sd51},
      '{CMD_VERTEX, -16'sd32768, -16'sd32768, -1, 16'sd0,   16'sd0},
      '{CMD_VERTEX, 16'sd32767,  16'sd32767,  -1, 16'sd0,   16'sd0},
      '{CMD_VERTEX, 16'sd500,    16'sd900,    -1, 16'sd0,   16'sd0},
      '{CMD_CLOSE,  16'sd0,      16'sd0,      -1, 16'sd0,   16'sd0},
      '{CMD_VERTEX, -16'sd5,     16'sd5,      0, 16'sd0,    16'sd0},
      '{CMD_VERTEX, -16'sd32768, 16'sd32767,  0, 16'sd0,    16'sd0},
      '{CMD_VERTEX, -16'sd1,     -16'sd1,     0, 16'sd0,    16'sd0},
      '{CMD_CLOSE,  16'sd0,      16'sd0,      0, 16'sd0,    16'sd0},
      '{CMD_VERTEX, 16'sd1023,   16'sd767,    1, 16'sd1023, 16'sd767},
      '{CMD_VERTEX, 16'sd1023,   16'sd767,    1, 16'sd1023, 16'sd767},
      '{CMD_VERTEX, 16'sd100,    -16'sd300,   -1, 16'sd0,   16'sd0},
      '{CMD_VERTEX, -16'sd400,   16'sd2000,   -1, 16'sd0,   16'sd0},
      '{CMD_VERTEX, 16'sd1500,   16'sd400,    -1, 16'sd0,   16'sd0},
      '{CMD_CLOSE,  16'sh7fff,   16'sh7fff,   -1, 16'sd0,   16'sd0}
   };

   // Stimulus
   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0; req_if.cmd = CMD_VERTEX;
      req_if.vertex_x = '0; req_if.vertex_y = '0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      win_xl = 0; win_xh = 1023; win_yl = 0; win_yh = 767;
      for (int e = 0; e < NUM_STAGES; e++) seen_st[e] = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         send_word(directed[i].cmd, directed[i].x, directed[i].y,
                   directed[i].n_typed, directed[i].ex, directed[i].ey);

      // Long receiver hold-off while words keep coming
      hold_rsp = 1;
      random_polys(15, 2048);
      hold_rsp = 0;

      // Swap idling profile
      send_gap_pct = 63; recv_stall_pct = 10;
      set_window(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
      random_polys(30, 65536);

      set_window(-16'sd100, 16'sd100, -16'sd50, 16'sd80);
      random_polys(35, 600);

      // Pause until every result is back
      wait (pending_words.size() == 0);
      repeat (50) @(posedge clock);

      send_gap_pct = 0; recv_stall_pct = 0;
      set_window(16'sd200, -16'sd200, 16'sd300, -16'sd300);
      random_polys(15, 1000);

      set_window(16'sd7, 16'sd7, -16'sd3, -16'sd3);
      random_polys(20, 40);

      set_window(coord_type'($urandom), coord_type'($urandom),
                 coord_type'($urandom), coord_type'($urandom));
      random_polys(30, 4096);

      wait (pending_words.size() == 0);
      repeat (400) @(posedge clock);
      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   // Drive result ready, with one long hold-off on request
   initial begin
      bit held = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp && !held) begin
            held = 1;
            rsp_if.ready <= 1'b0;
            repeat (600) @(posedge clock);
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Check each result word against the oldest expectation
   always @(posedge clock) begin
      clip_word_type w;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected word x=%0d y=%0d last=%0b", $time,
                     rsp_if.out_x, rsp_if.out_y, rsp_if.out_last);
            fail_count++;
         end else begin
            w = pending_words.pop_front();
            if (w.x !== rsp_if.out_x) begin
               $display("%0t: out_x expected %0d got %0d", $time, w.x, rsp_if.out_x);
               fail_count++;
            end
            if (w.y !== rsp_if.out_y) begin
               $display("%0t: out_y expected %0d got %0d", $time, w.y, rsp_if.out_y);
               fail_count++;
            end
            if (w.last !== rsp_if.out_last) begin
               $display("%0t: out_last expected %0b got %0b", $time, w.last,
                        rsp_if.out_last);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any handshake
   initial begin
      int quiet = 0;
      forever begin
         @(posedge clock);
         accepted = (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
                    || csr_psel || reset;
         quiet = accepted ? 0 : quiet + 1;
         if (quiet >= 20000) begin
            $display("%0t: no progress, %0d words outstanding", $time,
                     pending_words.size());
            $display("== FAIL ==");
            $finish;
         end
      end
   end

endmodule
